FILE: design/rdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared stream layout, opcodes, status codes and sequencer states of the
// ring deque block.
// ----------------------------------------------------------------------------
package rdq_pkg;

  // request stream layout (slave side)
  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 10;
  localparam int S_TDATA_W  = 48;
  localparam int OPCODE_LSB   = 0;
  localparam int VALUE_LSB    = OPCODE_LSB + OPCODE_W;
  localparam int POSITION_LSB = VALUE_LSB + VALUE_W;

  // result stream layout (master side)
  localparam int READ_VALUE_W = 32;
  localparam int FOUND_POS_W  = 10;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 11;
  localparam int M_TDATA_W    = 56;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ       = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

endpackage

FILE: design/rdq_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_wrap
// Shared index unit: adds a logical offset to the head and wraps the sum
// back into the ring with one compare and subtract.
// ----------------------------------------------------------------------------
module rdq_wrap #(
  parameter int DEPTH = 1024
) (
  input  logic [$clog2(DEPTH)-1:0] base,
  input  logic [$clog2(DEPTH)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] index
);
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  // both operands are below the depth, so one subtract is enough
  always_comb begin
    sum     = {1'b0, base} + {1'b0, offset};
    wrapped = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
    index   = wrapped[AW-1:0];
  end

endmodule

FILE: design/ring_deque_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_deque_with_search
// Double-ended queue in a circular store with push, pop, read and search.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on s_tvalid/s_tready/s_tdata and carry an opcode, a value
//   and a position. Each request gives exactly one result on
//   m_tvalid/m_tready/m_tdata with the read value, found position, status
//   and element count after the operation.
//   One request is handled at a time; s_tready is high only while the
//   sequencer is idle. A request is taken even while the previous result
//   still waits in the output register.
//   Push, pop and unused opcodes load their result in the EXEC state; read
//   issues the store read in EXEC and loads the result in READ; search
//   walks the store one entry per cycle in SCAN, through the single
//   registered read port and one comparator.
//   A new request is taken in the cycle after the previous result is loaded.
//   If the receiver stalls, the result is held and a following request is
//   parked until the output register frees up.
//   Reset empties the deque (head and count cleared); store contents are
//   left as they are and no clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_deque_with_search #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode [2:0], value [34:3], position [44:35], zero [47:45]
  input  logic [rdq_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // read_value [31:0], found_position [41:32], status [44:42],
  // element_count [55:45]
  output logic [rdq_pkg::M_TDATA_W-1:0] m_tdata
);
  import rdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer and deque state
  state_t              state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       idx, idx_next;

  // latched request
  logic [OPCODE_W-1:0]   op;
  logic [WIDTH-1:0]      key;
  logic [POSITION_W-1:0] pos;

  // store
  logic [WIDTH-1:0] store [DEPTH];
  logic [WIDTH-1:0] rdata;
  logic             mem_we;
  logic             mem_re;

  // index unit
  logic [AW-1:0] offset;
  logic [AW-1:0] phys;

  // result register
  logic [READ_VALUE_W-1:0] res_rv;
  logic [FOUND_POS_W-1:0]  res_fp;
  logic [STATUS_W-1:0]     res_st;
  logic [COUNT_W-1:0]      res_cnt;

  // result being loaded
  logic             out_load;
  logic             out_free;
  logic [STATUS_W-1:0] ld_st;
  logic [WIDTH-1:0] ld_rv;
  logic [AW-1:0]    ld_fp;

  // helpers
  logic                   full;
  logic                   empty;
  logic                   in_range;
  logic                   match;
  logic                   last;
  logic [AW-1:0]          idx_inc;
  logic [WIDTH+31:0]      key_ext;
  logic [AW+POSITION_W-1:0] pos_ext;
  logic [CW+POSITION_W-1:0] pos_cmp;
  logic [CW+POSITION_W-1:0] cnt_cmp;
  logic [WIDTH+31:0]      rv_ext;
  logic [AW+FOUND_POS_W-1:0] fp_ext;
  logic [CW+COUNT_W-1:0]  cnt_ext;

  rdq_wrap #(.DEPTH(DEPTH)) u_wrap (
    .base   (head),
    .offset (offset),
    .index  (phys)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {res_cnt, res_st, res_fp, res_rv};

  // conditions on the deque
  always_comb begin
    key_ext  = {32'd0, s_tdata[VALUE_LSB +: VALUE_W]};
    pos_ext  = {{AW{1'b0}}, pos};
    pos_cmp  = {{CW{1'b0}}, pos};
    cnt_cmp  = {{POSITION_W{1'b0}}, count};
    full     = (count == CW'(DEPTH));
    empty    = (count == '0);
    in_range = (pos_cmp < cnt_cmp);
    match    = (rdata == key);
    idx_inc  = idx + 1'b1;
    last     = ((CW'(idx) + 1'b1) == count);
  end

  // offset into the ring for the current step
  always_comb begin
    offset = '0;
    if (state == S_SCAN) begin
      offset = idx_inc;
    end else begin
      case (op)
        OP_PUSH_BACK:  offset = count[AW-1:0];
        OP_PUSH_FRONT: offset = AW'(DEPTH - 1);
        OP_POP_FRONT:  offset = AW'(1);
        OP_READ:       offset = pos_ext[AW-1:0];
        default:       offset = '0;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    out_load   = 1'b0;
    ld_st      = ST_OK;
    ld_rv      = '0;
    ld_fp      = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          out_load   = 1'b1;
          case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              if (full) begin
                ld_st = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  head_next = phys;
                end
              end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
              if (empty) begin
                ld_st = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
                if (op == OP_POP_FRONT) begin
                  head_next = phys;
                end
              end
            end
            OP_READ: begin
              if (in_range) begin
                mem_re     = 1'b1;
                out_load   = 1'b0;
                state_next = S_READ;
              end else begin
                ld_st = ST_RANGE;
              end
            end
            OP_SEARCH: begin
              idx_next = '0;
              if (empty) begin
                ld_st = ST_NOTFOUND;
              end else begin
                mem_re     = 1'b1;
                out_load   = 1'b0;
                state_next = S_SCAN;
              end
            end
            default: begin
              ld_st = ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        out_load   = 1'b1;
        ld_rv      = rdata;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (match) begin
          out_load   = 1'b1;
          ld_fp      = idx;
          state_next = S_IDLE;
        end else if (last) begin
          out_load   = 1'b1;
          ld_st      = ST_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          mem_re   = 1'b1;
          idx_next = idx_inc;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result field sizing
  always_comb begin
    rv_ext  = {32'd0, ld_rv};
    fp_ext  = {{FOUND_POS_W{1'b0}}, ld_fp};
    cnt_ext = {{COUNT_W{1'b0}}, count_next};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // request latch, scan index and result payload
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (s_tvalid && s_tready) begin
      op  <= s_tdata[OPCODE_LSB +: OPCODE_W];
      key <= key_ext[WIDTH-1:0];
      pos <= s_tdata[POSITION_LSB +: POSITION_W];
    end
    if (out_load) begin
      res_rv  <= rv_ext[READ_VALUE_W-1:0];
      res_fp  <= fp_ext[FOUND_POS_W-1:0];
      res_st  <= ld_st;
      res_cnt <= cnt_ext[COUNT_W-1:0];
    end
  end

  // element store, one access per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[phys] <= key;
    end
    if (mem_re) begin
      rdata <= store[phys];
    end
  end

endmodule

FILE: design/rdq_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_check
// Port-level checks on the ring deque: result hold under stall, one request
// at a time, and consistency of status with the other result fields.
// ----------------------------------------------------------------------------
module rdq_check #(
  parameter int DEPTH = 1024
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rdq_pkg::M_TDATA_W-1:0] m_tdata
);
  import rdq_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [COUNT_W-1:0]  cnt;

  assign st  = m_tdata[44:42];
  assign cnt = m_tdata[55:45];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // failed operations return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st != ST_OK) |-> (m_tdata[31:0] == 32'd0) && (m_tdata[41:32] == 10'd0))
    else $error("data on a failed result");

  // full reported only at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_FULL) |-> (cnt == COUNT_W'(DEPTH)))
    else $error("full status below capacity");

  // empty reported only with no elements
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_EMPTY) |-> (cnt == '0))
    else $error("empty status with elements held");

endmodule

bind ring_deque_with_search rdq_check #(.DEPTH(DEPTH)) u_rdq_check (.*);
